[design/i2c_master_byte_sequencer_macros.svh]
// ----------------------------------------------------------------------------
// I2C master byte sequencer assertion macros
// Concurrent assertion shorthands clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH
`define I2C_MASTER_BYTE_SEQUENCER_MACROS_SVH

// same-cycle implication
`define I2CM_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("i2c sequencer check failed");

// next-cycle implication
`define I2CM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("i2c sequencer check failed");

`endif

[design/i2cm_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master byte sequencer package
// Command codes, phase numbers, item and result types.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	typedef enum logic [2:0] {
		FN_TICK  = 3'd0,
		FN_START = 3'd1,
		FN_STOP  = 3'd2,
		FN_WRITE = 3'd3,
		FN_READ  = 3'd4
	} func_t;

	// phase number of the running command; meaning depends on the command
	typedef logic [2:0] phase_t;
	localparam phase_t PH_IDLE = 3'd0;
	localparam phase_t PH_1    = 3'd1;
	localparam phase_t PH_2    = 3'd2;
	localparam phase_t PH_3    = 3'd3;
	localparam phase_t PH_4    = 3'd4;
	localparam phase_t PH_5    = 3'd5;
	localparam phase_t PH_6    = 3'd6;

	localparam int          TICK_W          = 16;
	localparam logic [15:0] PHASE_TICKS_RST = 16'd20;
	localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

	typedef struct packed {
		logic [2:0] func;
		logic [7:0] tx_byte;
		logic       send_ack;
		logic       sda_sense;
	} item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       acked;
		logic       refused;
	} res_t;

endpackage

[design/i2c_master_byte_sequencer.sv]
// ----------------------------------------------------------------------------
// I2C master byte sequencer
// Open-drain SCL/SDA pin sequencer for start, stop, byte write and byte read.
// ----------------------------------------------------------------------------
// channel  dir  handshake             payload
// s_*      in   s_tvalid / s_tready   tuser: func; tdata: tx_byte, send_ack, sda_sense
// m_*      out  m_tvalid / m_tready   tdata: pins, busy, done, rx_byte, acked, refused
// cfg_*    in   cfg_valid / cfg_ready cfg_data: phase_ticks
//
// One item per cycle sustained while m_tready holds. An accepted item waits in the
// input register, its result is computed against the sequencer state and lands in
// the output register, from which it is offered on m_*. arst_n clears the state
// to idle with both pins released and phase_ticks 20.
// A stalled output holds its result; the input register keeps taking items
// until it is also full.
// ----------------------------------------------------------------------------
module i2c_master_byte_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,	// [7:0] tx_byte, [8] send_ack, [9] sda_sense, [15:10] zero
	input  logic [2:0]  s_tuser,	// [2:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,	// [0] scl_level, [1] sda_level, [2] busy_res, [3] done_res,
					// [11:4] rx_byte, [12] acked, [13] refused, [15:14] zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data	// [15:0] phase_ticks
);

	logic                        valid_s1;
	i2cm_pkg::item_t             item_s1;
	logic                        valid_s2;
	i2cm_pkg::res_t              res_s2;
	i2cm_pkg::res_t              core_res;
	logic [i2cm_pkg::TICK_W-1:0] phase_q;
	logic                        adv_s1;

	assign adv_s1    = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cm_pkg::PHASE_TICKS_RST;
		end else if (cfg_valid) begin
			phase_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func      <= s_tuser;
			item_s1.tx_byte   <= s_tdata[7:0];
			item_s1.send_ack  <= s_tdata[8];
			item_s1.sda_sense <= s_tdata[9];
		end
		if (adv_s1) begin
			res_s2 <= core_res;
		end
	end

	i2cm_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (adv_s1),
		.item        (item_s1),
		.phase_ticks (phase_q),
		.res         (core_res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {2'b00, res_s2.refused, res_s2.acked, res_s2.rx_byte,
			   res_s2.done_res, res_s2.busy_res, res_s2.sda_level, res_s2.scl_level};

`include "i2c_master_byte_sequencer_macros.svh"

	`I2CM_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s1, valid_s1 && $stable(item_s1))
	`I2CM_ASSERT_NEXT(a_out_load, adv_s1, m_tvalid)
	`I2CM_ASSERT_IMP(a_refused_busy, m_tvalid && m_tdata[13], m_tdata[2] && !m_tdata[3])

endmodule

[design/i2cm_core.sv]
// ----------------------------------------------------------------------------
// I2C master byte sequencer core
// Sequencer state and the next-state logic for one item per cycle while step_en is high.
// ----------------------------------------------------------------------------
module i2cm_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step_en,
	input  i2cm_pkg::item_t                 item,
	input  logic [i2cm_pkg::TICK_W-1:0]     phase_ticks,
	output i2cm_pkg::res_t                  res
);

	i2cm_pkg::phase_t            step_q,  step_nx;
	i2cm_pkg::func_t             cmd_q,   cmd_nx;
	logic [i2cm_pkg::TICK_W-1:0] wait_q,  wait_nx;
	logic [7:0]                  shift_q, shift_nx;
	logic [3:0]                  bit_q,   bit_nx;
	logic                        scl_q,   scl_nx;
	logic                        sda_q,   sda_nx;
	logic                        ack_q,   ack_nx;
	logic                        sack_q,  sack_nx;
	logic [7:0]                  rx_q,    rx_nx;
	logic                        done, refused;

	always_comb begin
		logic [i2cm_pkg::TICK_W-1:0] load, wait_dec;
		logic [3:0]                  bit_inc;
		logic                        busy, cont;
		i2cm_pkg::phase_t            ph;

		step_nx  = step_q;
		cmd_nx   = cmd_q;
		wait_nx  = wait_q;
		shift_nx = shift_q;
		bit_nx   = bit_q;
		scl_nx   = scl_q;
		sda_nx   = sda_q;
		ack_nx   = ack_q;
		sack_nx  = sack_q;
		rx_nx    = rx_q;
		done     = 1'b0;
		refused  = 1'b0;
		cont     = 1'b0;
		ph       = i2cm_pkg::PH_IDLE;

		// zero phase length behaves as one tick
		load     = (phase_ticks == '0) ? {{(i2cm_pkg::TICK_W-1){1'b0}}, 1'b1} : phase_ticks;
		wait_dec = wait_q - {{(i2cm_pkg::TICK_W-1){1'b0}}, 1'b1};
		bit_inc  = bit_q + 4'd1;
		busy     = (step_q != i2cm_pkg::PH_IDLE);

		if (step_en) begin
			case (item.func) inside
				i2cm_pkg::FN_TICK: begin
					if (busy) begin
						wait_nx = wait_dec;
						if (wait_dec == '0) begin
							case (cmd_q)
								i2cm_pkg::FN_START: begin
									if (step_q == i2cm_pkg::PH_1) begin
										sda_nx = 1'b0; ph = i2cm_pkg::PH_2; cont = 1'b1;
									end else if (step_q == i2cm_pkg::PH_2) begin
										scl_nx = 1'b0; ph = i2cm_pkg::PH_3; cont = 1'b1;
									end
								end
								i2cm_pkg::FN_STOP: begin
									if (step_q == i2cm_pkg::PH_1) begin
										sda_nx = 1'b1; ph = i2cm_pkg::PH_2; cont = 1'b1;
									end
								end
								i2cm_pkg::FN_WRITE: begin
									case (step_q)
										i2cm_pkg::PH_1: begin
											scl_nx = 1'b1; ph = i2cm_pkg::PH_2; cont = 1'b1;
										end
										i2cm_pkg::PH_2: begin
											scl_nx = 1'b0; ph = i2cm_pkg::PH_3; cont = 1'b1;
										end
										i2cm_pkg::PH_3: begin
											shift_nx = {shift_q[6:0], 1'b0};
											bit_nx   = bit_inc;
											cont     = 1'b1;
											if (bit_inc < i2cm_pkg::BITS_PER_BYTE) begin
												sda_nx = shift_q[6];
												ph     = i2cm_pkg::PH_1;
											end else begin
												// release SDA for the acknowledge bit
												sda_nx = 1'b1;
												ph     = i2cm_pkg::PH_4;
											end
										end
										i2cm_pkg::PH_4: begin
											scl_nx = 1'b1; ph = i2cm_pkg::PH_5; cont = 1'b1;
										end
										i2cm_pkg::PH_5: begin
											ack_nx = ~item.sda_sense;
											scl_nx = 1'b0; ph = i2cm_pkg::PH_6; cont = 1'b1;
										end
										default: ;
									endcase
								end
								i2cm_pkg::FN_READ: begin
									case (step_q)
										i2cm_pkg::PH_1: begin
											// sample at the end of SCL high
											shift_nx = {shift_q[6:0], item.sda_sense};
											scl_nx   = 1'b0; ph = i2cm_pkg::PH_2; cont = 1'b1;
										end
										i2cm_pkg::PH_2: begin
											bit_nx = bit_inc;
											cont   = 1'b1;
											if (bit_inc < i2cm_pkg::BITS_PER_BYTE) begin
												scl_nx = 1'b1;
												ph     = i2cm_pkg::PH_1;
											end else begin
												sda_nx = ~sack_q;
												ph     = i2cm_pkg::PH_3;
											end
										end
										i2cm_pkg::PH_3: begin
											scl_nx = 1'b1; ph = i2cm_pkg::PH_4; cont = 1'b1;
										end
										i2cm_pkg::PH_4: begin
											scl_nx = 1'b0; ph = i2cm_pkg::PH_5; cont = 1'b1;
										end
										i2cm_pkg::PH_5: begin
											sda_nx = 1'b1;
											rx_nx  = shift_q;
										end
										default: ;
									endcase
								end
								default: ;
							endcase
							if (cont) begin
								step_nx = ph;
								wait_nx = load;
							end else begin
								step_nx = i2cm_pkg::PH_IDLE;
								wait_nx = '0;
								done    = 1'b1;
							end
						end
					end
				end
				i2cm_pkg::FN_START, i2cm_pkg::FN_STOP, i2cm_pkg::FN_WRITE,
				i2cm_pkg::FN_READ: begin
					if (busy) begin
						refused = 1'b1;
					end else begin
						cmd_nx  = i2cm_pkg::func_t'(item.func);
						step_nx = i2cm_pkg::PH_1;
						wait_nx = load;
						case (item.func)
							i2cm_pkg::FN_START: begin
								sda_nx = 1'b1; scl_nx = 1'b1;
							end
							i2cm_pkg::FN_STOP: begin
								sda_nx = 1'b0; scl_nx = 1'b1;
							end
							i2cm_pkg::FN_WRITE: begin
								shift_nx = item.tx_byte;
								bit_nx   = 4'd0;
								sda_nx   = item.tx_byte[7];
							end
							default: begin
								shift_nx = 8'd0;
								bit_nx   = 4'd0;
								sack_nx  = item.send_ack;
								sda_nx   = 1'b1; scl_nx = 1'b1;
							end
						endcase
					end
				end
				default: ;	// undefined codes are ignored
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= i2cm_pkg::PH_IDLE;
			cmd_q   <= i2cm_pkg::FN_TICK;
			wait_q  <= '0;
			shift_q <= 8'd0;
			bit_q   <= 4'd0;
			scl_q   <= 1'b1;
			sda_q   <= 1'b1;
			ack_q   <= 1'b0;
			sack_q  <= 1'b0;
			rx_q    <= 8'd0;
		end else if (step_en) begin
			step_q  <= step_nx;
			cmd_q   <= cmd_nx;
			wait_q  <= wait_nx;
			shift_q <= shift_nx;
			bit_q   <= bit_nx;
			scl_q   <= scl_nx;
			sda_q   <= sda_nx;
			ack_q   <= ack_nx;
			sack_q  <= sack_nx;
			rx_q    <= rx_nx;
		end
	end

	always_comb begin
		res.scl_level = scl_nx;
		res.sda_level = sda_nx;
		res.busy_res  = (step_nx != i2cm_pkg::PH_IDLE);
		res.done_res  = done;
		res.rx_byte   = rx_nx;
		res.acked     = ack_nx;
		res.refused   = refused;
	end

endmodule

[tb/sv/tb_i2c_master_byte_sequencer.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the I2C master byte sequencer
// A directed table first covers reset pin levels, refusal while busy,
// undefined commands and byte write/read extremes. Random command sequences
// follow at several phase lengths, ending with a short look at the longest
// one. Every result is checked field by field against a typed expectation or a
// cycle-free pin predictor, with random stalls on both stream sides.
// ----------------------------------------------------------------------------
module tb_i2c_master_byte_sequencer;

	localparam logic [2:0]  FN_UNDEF_LO = 3'd5;
	localparam logic [2:0]  FN_UNDEF_HI = 3'd7;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          RUN_TO_IDLE = -1;
	localparam int          RELOAD_PHASE = -2;
	localparam logic [15:0] DIR_PHASE = 16'd2;
	localparam int          RAND_BUDGET = 150;
	localparam int          LONG_TICKS = 24;

	// typed expectations: scl, sda, busy, done, rx_byte, acked, refused
	localparam i2cm_pkg::res_t RES_IDLE      = {1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0};
	localparam i2cm_pkg::res_t RES_START     = {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
	localparam i2cm_pkg::res_t RES_START_REF = {1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1};
	localparam i2cm_pkg::res_t RES_SDA_LOW   = {1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0};
	localparam i2cm_pkg::res_t RES_WR_REF    = {1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1};

	typedef struct {
		i2cm_pkg::item_t it;
		int              reps;
		bit              typed;
		i2cm_pkg::res_t  want;
	} drow_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;	// [7:0] tx_byte, [8] send_ack, [9] sda_sense, [15:10] zero
	logic [2:0]  s_tuser = '0;	// [2:0] func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;		// [0] scl, [1] sda, [2] busy, [3] done, [11:4] rx_byte,
					// [12] acked, [13] refused, [15:14] zero
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;	// [15:0] phase_ticks

	// pin predictor state
	logic [15:0]      ptick    = i2cm_pkg::PHASE_TICKS_RST;
	i2cm_pkg::phase_t seq_ph   = i2cm_pkg::PH_IDLE;
	logic [2:0]       cmd_q    = i2cm_pkg::FN_TICK;
	logic [15:0]      wait_q   = '0;
	logic [7:0]       shift_q  = '0;
	logic [3:0]       bitn_q   = '0;
	logic             scl_q    = 1'b1;
	logic             sda_q    = 1'b1;
	logic             ack_q    = 1'b0;
	logic             ack_plan = 1'b0;
	logic [7:0]       rx_last  = '0;

	i2cm_pkg::res_t pin_q[$];
	int    mismatches = 0;
	int    results_seen = 0;
	int    items_sent = 0;
	int    idle_cycles = 0;
	bit    gaps_on = 1'b1;
	drow_t dtab[$];

	i2c_master_byte_sequencer i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void arm_wait(input i2cm_pkg::phase_t nxt);
		wait_q = (ptick == 16'd0) ? 16'd1 : ptick;
		seq_ph = nxt;
	endfunction

	function automatic i2cm_pkg::res_t predict_step(input i2cm_pkg::item_t it);
		i2cm_pkg::res_t   r;
		logic             fin;
		logic             was_busy;
		i2cm_pkg::phase_t cur;
		fin = 1'b0;
		was_busy = (seq_ph != i2cm_pkg::PH_IDLE);
		r = '0;
		if (it.func == i2cm_pkg::FN_TICK) begin
			if (was_busy) begin
				wait_q = wait_q - 16'd1;
				if (wait_q == 16'd0) begin
					// phase runs out; the command ends unless a phase re-arms the wait
					cur = seq_ph;
					seq_ph = i2cm_pkg::PH_IDLE;
					case (cmd_q)
					i2cm_pkg::FN_START: begin
						if (cur == i2cm_pkg::PH_1) begin
							sda_q = 1'b0;
							arm_wait(i2cm_pkg::PH_2);
						end else if (cur == i2cm_pkg::PH_2) begin
							scl_q = 1'b0;
							arm_wait(i2cm_pkg::PH_3);
						end
					end
					i2cm_pkg::FN_STOP: begin
						if (cur == i2cm_pkg::PH_1) begin
							sda_q = 1'b1;
							arm_wait(i2cm_pkg::PH_2);
						end
					end
					i2cm_pkg::FN_WRITE: begin
						case (cur)
						i2cm_pkg::PH_1: begin
							scl_q = 1'b1;
							arm_wait(i2cm_pkg::PH_2);
						end
						i2cm_pkg::PH_2: begin
							scl_q = 1'b0;
							arm_wait(i2cm_pkg::PH_3);
						end
						i2cm_pkg::PH_3: begin
							shift_q = shift_q << 1;
							bitn_q = bitn_q + 4'd1;
							if (bitn_q < i2cm_pkg::BITS_PER_BYTE) begin
								sda_q = shift_q[7];
								arm_wait(i2cm_pkg::PH_1);
							end else begin
								sda_q = 1'b1;
								arm_wait(i2cm_pkg::PH_4);
							end
						end
						i2cm_pkg::PH_4: begin
							scl_q = 1'b1;
							arm_wait(i2cm_pkg::PH_5);
						end
						i2cm_pkg::PH_5: begin
							ack_q = (it.sda_sense == 1'b0);
							scl_q = 1'b0;
							arm_wait(i2cm_pkg::PH_6);
						end
						default: ;
						endcase
					end
					i2cm_pkg::FN_READ: begin
						case (cur)
						i2cm_pkg::PH_1: begin
							shift_q = {shift_q[6:0], it.sda_sense};
							scl_q = 1'b0;
							arm_wait(i2cm_pkg::PH_2);
						end
						i2cm_pkg::PH_2: begin
							bitn_q = bitn_q + 4'd1;
							if (bitn_q < i2cm_pkg::BITS_PER_BYTE) begin
								scl_q = 1'b1;
								arm_wait(i2cm_pkg::PH_1);
							end else begin
								sda_q = ~ack_plan;
								arm_wait(i2cm_pkg::PH_3);
							end
						end
						i2cm_pkg::PH_3: begin
							scl_q = 1'b1;
							arm_wait(i2cm_pkg::PH_4);
						end
						i2cm_pkg::PH_4: begin
							scl_q = 1'b0;
							arm_wait(i2cm_pkg::PH_5);
						end
						i2cm_pkg::PH_5: begin
							sda_q = 1'b1;
							rx_last = shift_q;
						end
						default: ;
						endcase
					end
					default: ;
					endcase
					if (seq_ph == i2cm_pkg::PH_IDLE) begin
						fin = 1'b1;
						wait_q = '0;
					end
				end
			end
		end else if (it.func <= i2cm_pkg::FN_READ) begin
			if (was_busy) begin
				r.refused = 1'b1;
			end else begin
				cmd_q = it.func;
				case (it.func)
				i2cm_pkg::FN_START: begin
					sda_q = 1'b1;
					scl_q = 1'b1;
				end
				i2cm_pkg::FN_STOP: begin
					sda_q = 1'b0;
					scl_q = 1'b1;
				end
				i2cm_pkg::FN_WRITE: begin
					shift_q = it.tx_byte;
					bitn_q = '0;
					sda_q = it.tx_byte[7];
				end
				default: begin
					shift_q = '0;
					bitn_q = '0;
					ack_plan = it.send_ack;
					sda_q = 1'b1;
					scl_q = 1'b1;
				end
				endcase
				arm_wait(i2cm_pkg::PH_1);
			end
		end
		r.scl_level = scl_q;
		r.sda_level = sda_q;
		r.busy_res = (seq_ph != i2cm_pkg::PH_IDLE);
		r.done_res = fin;
		r.rx_byte = rx_last;
		r.acked = ack_q;
		return r;
	endfunction

	function automatic int pick_gap();
		int p;
		if (!gaps_on)
			return 0;
		p = $urandom_range(0, 99);
		if (p < 60)
			return 0;
		if (p < 94)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic i2cm_pkg::item_t rand_item(input logic [2:0] fn);
		i2cm_pkg::item_t it;
		it.func = fn;
		it.tx_byte = 8'($urandom_range(0, 255));
		it.send_ack = 1'($urandom_range(0, 1));
		it.sda_sense = 1'($urandom_range(0, 1));
		return it;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
			input logic [15:0] want);
		mismatches++;
		$display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
			results_seen, what, got, want);
	endtask

	task automatic check_field(input string what, input logic [7:0] got, input logic [7:0] want);
		if (got !== want)
			report_mismatch(what, {8'd0, got}, {8'd0, want});
	endtask

	task automatic push_item(input i2cm_pkg::item_t it, input bit typed,
			input i2cm_pkg::res_t want);
		int             gap;
		i2cm_pkg::res_t r;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= it.func;
		s_tdata <= {6'd0, it.sda_sense, it.send_ack, it.tx_byte};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		r = predict_step(it);
		pin_q.push_back(typed ? want : r);
	endtask

	// tick until the running command ends; with noise, stray commands get mixed in
	task automatic run_out(input bit noise);
		while (seq_ph != i2cm_pkg::PH_IDLE) begin
			if (noise && $urandom_range(0, 15) == 0)
				push_item(rand_item(3'($urandom_range(i2cm_pkg::FN_START, FN_UNDEF_HI))),
					1'b0, '0);
			else
				push_item(rand_item(i2cm_pkg::FN_TICK), 1'b0, '0);
		end
	endtask

	task automatic set_phase_ticks(input logic [15:0] v);
		s_tvalid <= 1'b0;
		while (pin_q.size() != 0) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ptick = v;
	endtask

	task automatic run_traffic(input int budget);
		int start_cnt;
		int k;
		start_cnt = items_sent;
		while (items_sent - start_cnt < budget) begin
			gaps_on = ($urandom_range(0, 4) != 0);
			k = $urandom_range(0, 19);
			if (k == 0) begin
				push_item(rand_item(i2cm_pkg::FN_TICK), 1'b0, '0);
			end else if (k == 1) begin
				push_item(rand_item(3'($urandom_range(FN_UNDEF_LO, FN_UNDEF_HI))), 1'b0, '0);
			end else begin
				push_item(rand_item(3'($urandom_range(i2cm_pkg::FN_START,
					i2cm_pkg::FN_READ))), 1'b0, '0);
				run_out(1'b1);
			end
		end
	endtask

	// result checker
	always @(posedge clk) begin
		i2cm_pkg::res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pin_q.size() == 0) begin
				report_mismatch("unexpected result", m_tdata, 16'd0);
			end else begin
				want = pin_q.pop_front();
				check_field("scl_level", {7'd0, m_tdata[0]}, {7'd0, want.scl_level});
				check_field("sda_level", {7'd0, m_tdata[1]}, {7'd0, want.sda_level});
				check_field("busy_res", {7'd0, m_tdata[2]}, {7'd0, want.busy_res});
				check_field("done_res", {7'd0, m_tdata[3]}, {7'd0, want.done_res});
				check_field("rx_byte", m_tdata[11:4], want.rx_byte);
				check_field("acked", {7'd0, m_tdata[12]}, {7'd0, want.acked});
				check_field("refused", {7'd0, m_tdata[13]}, {7'd0, want.refused});
			end
		end
	end

	// output-side backpressure
	initial begin
		int g;
		wait (arst_n);
		forever begin
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			g = pick_gap();
			if (g > 0) begin
				m_tready <= 1'b0;
				repeat (g) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		logic [15:0] settings[$];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// directed part, first rows at the reset phase length
		dtab.push_back('{'{i2cm_pkg::FN_TICK, 8'h00, 1'b0, 1'b0}, 1, 1'b1, RES_IDLE});
		dtab.push_back('{'{FN_UNDEF_LO, 8'h00, 1'b0, 1'b0}, 1, 1'b1, RES_IDLE});
		dtab.push_back('{'{FN_UNDEF_HI, 8'hFF, 1'b1, 1'b1}, 1, 1'b1, RES_IDLE});
		dtab.push_back('{'{i2cm_pkg::FN_START, 8'h00, 1'b0, 1'b0}, 1, 1'b1, RES_START});
		dtab.push_back('{'{i2cm_pkg::FN_WRITE, 8'hFF, 1'b1, 1'b1}, 1, 1'b1, RES_START_REF});
		dtab.push_back('{'{i2cm_pkg::FN_TICK, 8'h00, 1'b0, 1'b1}, 19, 1'b0, '0});
		// last tick of the first phase pulls SDA low
		dtab.push_back('{'{i2cm_pkg::FN_TICK, 8'h00, 1'b0, 1'b1}, 1, 1'b1, RES_SDA_LOW});
		dtab.push_back('{'{i2cm_pkg::FN_TICK, 8'h00, 1'b0, 1'b1}, RUN_TO_IDLE, 1'b0, '0});
		// byte commands run at a short phase length
		dtab.push_back('{'{i2cm_pkg::FN_TICK, 8'h00, 1'b0, 1'b0}, RELOAD_PHASE, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_WRITE, 8'h00, 1'b0, 1'b0}, 1, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_READ, 8'h00, 1'b1, 1'b0}, 1, 1'b1, RES_WR_REF});
		dtab.push_back('{'{i2cm_pkg::FN_TICK, 8'h00, 1'b0, 1'b0}, RUN_TO_IDLE, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_WRITE, 8'hFF, 1'b1, 1'b1}, 1, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_TICK, 8'h00, 1'b0, 1'b1}, RUN_TO_IDLE, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_WRITE, 8'hA5, 1'b0, 1'b0}, 1, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_TICK, 8'h5A, 1'b1, 1'b0}, RUN_TO_IDLE, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_READ, 8'h00, 1'b1, 1'b1}, 1, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_TICK, 8'h00, 1'b0, 1'b1}, RUN_TO_IDLE, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_READ, 8'hFF, 1'b0, 1'b0}, 1, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_TICK, 8'hFF, 1'b1, 1'b0}, RUN_TO_IDLE, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_STOP, 8'h00, 1'b0, 1'b0}, 1, 1'b0, '0});
		dtab.push_back('{'{i2cm_pkg::FN_TICK, 8'h00, 1'b0, 1'b0}, RUN_TO_IDLE, 1'b0, '0});
		dtab.push_back('{'{FN_UNDEF_LO + 3'd1, 8'h3C, 1'b1, 1'b1}, 1, 1'b0, '0});
		foreach (dtab[i]) begin
			if (dtab[i].reps == RUN_TO_IDLE)
				run_out(1'b0);
			else if (dtab[i].reps == RELOAD_PHASE)
				set_phase_ticks(DIR_PHASE);
			else
				repeat (dtab[i].reps) push_item(dtab[i].it, dtab[i].typed, dtab[i].want);
		end

		// random part over several phase lengths; zero behaves as one
		settings = '{16'd0, 16'd1, 16'd2, 16'd3, 16'($urandom_range(1, 5)),
			16'($urandom_range(0, 7)), i2cm_pkg::PHASE_TICKS_RST};
		foreach (settings[i]) begin
			set_phase_ticks(settings[i]);
			run_traffic(RAND_BUDGET);
		end

		// longest phase: one stop, one refused write, a few ticks, no stalls
		set_phase_ticks(16'hFFFF);
		gaps_on = 1'b0;
		push_item(rand_item(i2cm_pkg::FN_STOP), 1'b0, '0);
		push_item(rand_item(i2cm_pkg::FN_WRITE), 1'b0, '0);
		repeat (LONG_TICKS) push_item(rand_item(i2cm_pkg::FN_TICK), 1'b0, '0);

		s_tvalid <= 1'b0;
		while (pin_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[files.f]
+incdir+design
design/i2cm_pkg.sv
design/i2cm_core.sv
design/i2c_master_byte_sequencer.sv
tb/sv/tb_i2c_master_byte_sequencer.sv
